### sv/lpq_pkg.sv
// ============================================================================
// lpq_pkg: shared definitions for the quarter-scan LED panel driver
// Holds the request codes, register indexes, command and result formats
// and the state types used by the front end, back end and top level.
// ============================================================================
package lpq_pkg;

    // Default and largest panel geometry.
    localparam int PANEL_WIDTH_DEF  = 32;
    localparam int PANEL_HEIGHT_DEF = 16;
    localparam int PANEL_WIDTH_MAX  = 256;
    localparam int PANEL_HEIGHT_MAX = 64;

    // Command address field covers the largest frame store.
    localparam int CMD_ADDR_W = $clog2(((PANEL_WIDTH_MAX + 7) / 8) * PANEL_HEIGHT_MAX);

    // Queue depths, both powers of two.
    localparam int CMD_FIFO_DEPTH = 4;
    localparam int OUT_FIFO_DEPTH = 4;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int PAUSE_W    = 16;
    localparam int WAIT_W     = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_NEGATIVE_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_TICKS   = 1'b1;

    localparam logic [PAUSE_W-1:0] PAUSE_RESET = 16'd1;
    localparam logic [WAIT_W-1:0]  WAIT_MAX    = '1;
    localparam logic [7:0]         BYTE_ONES   = 8'hFF;

    // Request action codes.
    typedef logic [2:0] t_action;
    localparam t_action ACT_PIXEL  = 3'd0;
    localparam t_action ACT_FILL   = 3'd1;
    localparam t_action ACT_COMMIT = 3'd2;
    localparam t_action ACT_SHOW   = 3'd3;
    localparam t_action ACT_OFF    = 3'd4;
    localparam t_action ACT_TICK   = 3'd5;

    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_SEND,
        SCAN_WAIT
    } t_scan_mode;

    typedef enum logic [1:0] {
        CMD_PIXEL,
        CMD_FILL,
        CMD_COMMIT,
        CMD_EMIT
    } t_cmd_op;

    // One unit of work for the back end. For a pixel, data[0] is the new
    // pixel value; for a fill, data is the byte pattern.
    typedef struct packed {
        t_cmd_op                 op;
        logic [CMD_ADDR_W-1:0]   addr;
        logic [2:0]              bit_sel;
        logic [7:0]              data;
        logic [1:0]              quarter;
    } t_cmd;

    typedef struct packed {
        logic clearing;
    } t_back_status;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_FILL,
        BK_COPY,
        BK_PIX_RD,
        BK_PIX_WR,
        BK_EMIT
    } t_back_state;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [1:0] row_select;
        logic       last_of_quarter;
    } t_result;

endpackage

### sv/lpq_fifo.sv
// ============================================================================
// lpq_fifo: small register queue
// Synchronous first-in first-out queue in flip-flops. DEPTH must be a
// power of two. Pushes while full and pops while empty are ignored.
// ============================================================================
module lpq_fifo import lpq_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = CMD_FIFO_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_rdata,
    output logic                       o_full,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_level
);

    localparam int PW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [LW-1:0]    r_level;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_level == LW'(DEPTH));
    assign o_empty = (r_level == '0);
    assign o_level = r_level;
    assign o_rdata = r_mem[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({push_ok, pop_ok})
                2'b10:   r_level <= r_level + 1'b1;
                2'b01:   r_level <= r_level - 1'b1;
                default: r_level <= r_level;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

### sv/lpq_front.sv
// ============================================================================
// lpq_front: request decoder and scan sequencer
// Takes requests, keeps the configuration and the refresh mode, and turns
// each request into at most one command for the back end.
// ============================================================================
module lpq_front import lpq_pkg::*; #(
    parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic [2:0]            i_action,
    input  logic signed [15:0]    i_pos_x,
    input  logic signed [15:0]    i_pos_y,
    input  logic                  i_pixel_on,
    input  t_back_status          i_back_status,
    input  logic                  i_cmd_full,
    output logic                  o_cmd_push,
    output t_cmd                  o_cmd
);

    localparam int ROW_BYTES   = (PANEL_WIDTH + 7) / 8;
    localparam int FRAME_BYTES = ROW_BYTES * PANEL_HEIGHT;
    localparam int AW          = $clog2(FRAME_BYTES);

    logic               r_neg;
    logic [PAUSE_W-1:0] r_pause;
    t_scan_mode         r_mode;
    t_scan_mode         n_mode;
    logic [1:0]         r_quarter;
    logic [1:0]         n_quarter;
    logic [WAIT_W-1:0]  r_wait;
    logic [WAIT_W-1:0]  n_wait;

    logic               accept;
    logic [15:0]        x_u;
    logic [15:0]        y_u;
    logic               in_range;
    logic [AW-1:0]      pix_addr;
    logic [WAIT_W-1:0]  wait_inc;
    logic               wait_over;
    logic               tick_emit;

    assign o_full   = i_cmd_full || i_back_status.clearing;
    assign accept   = i_push && !o_full;
    assign x_u      = i_pos_x;
    assign y_u      = i_pos_y;
    assign in_range = !i_pos_x[15] && !i_pos_y[15]
                      && (x_u < 16'(PANEL_WIDTH)) && (y_u < 16'(PANEL_HEIGHT));
    assign pix_addr = AW'(int'(y_u) * ROW_BYTES + int'(x_u >> 3));

    // The wait count saturates; it is compared after the increment.
    assign wait_inc  = (r_wait == WAIT_MAX) ? r_wait : r_wait + 1'b1;
    assign wait_over = (wait_inc > WAIT_W'(r_pause));
    assign tick_emit = (r_mode == SCAN_SEND) || ((r_mode == SCAN_WAIT) && wait_over);

    // Refresh mode, quarter and wait count.
    always_comb begin
        n_mode    = r_mode;
        n_quarter = r_quarter;
        n_wait    = r_wait;
        if (accept) begin
            unique case (i_action)
                ACT_SHOW: begin
                    if (r_mode == SCAN_IDLE) begin
                        n_mode = SCAN_SEND;
                    end
                end
                ACT_OFF: begin
                    n_mode = SCAN_IDLE;
                end
                ACT_TICK: begin
                    if (r_mode == SCAN_WAIT) begin
                        n_wait = wait_inc;
                    end
                    if (tick_emit) begin
                        n_quarter = r_quarter + 1'b1;
                        n_wait    = '0;
                        n_mode    = SCAN_WAIT;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Command to the back end.
    always_comb begin
        o_cmd_push     = 1'b0;
        o_cmd.op       = CMD_PIXEL;
        o_cmd.addr     = CMD_ADDR_W'(pix_addr);
        o_cmd.bit_sel  = ~x_u[2:0];
        o_cmd.data     = {7'd0, i_pixel_on ^ r_neg};
        o_cmd.quarter  = r_quarter;
        unique case (i_action)
            ACT_PIXEL: begin
                o_cmd_push = accept && in_range;
            end
            ACT_FILL: begin
                o_cmd_push = accept;
                o_cmd.op   = CMD_FILL;
                o_cmd.data = {8{i_pixel_on ^ r_neg}};
            end
            ACT_COMMIT: begin
                o_cmd_push = accept;
                o_cmd.op   = CMD_COMMIT;
            end
            ACT_OFF: begin
                o_cmd_push = accept;
                o_cmd.op   = CMD_FILL;
                o_cmd.data = {8{r_neg}};
            end
            ACT_TICK: begin
                o_cmd_push = accept && tick_emit;
                o_cmd.op   = CMD_EMIT;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= SCAN_IDLE;
            r_quarter <= '0;
            r_wait    <= '0;
        end else begin
            r_mode    <= n_mode;
            r_quarter <= n_quarter;
            r_wait    <= n_wait;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neg   <= 1'b0;
            r_pause <= PAUSE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NEGATIVE_MODE: r_neg   <= i_cfg_wdata[0];
                CFG_PAUSE_TICKS:   r_pause <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_send_tick_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_action == ACT_TICK) && (r_mode == SCAN_SEND))
        |-> (o_cmd_push && (o_cmd.op == CMD_EMIT)))
        else $error("tick in send mode did not issue a quarter");

    a_emit_enters_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_push && (o_cmd.op == CMD_EMIT))
        |=> ((r_mode == SCAN_WAIT) && (r_wait == '0)
             && (r_quarter == $past(r_quarter) + 2'd1)))
        else $error("quarter emission did not restart the wait");
`endif

endmodule

### sv/lpq_back.sv
// ============================================================================
// lpq_back: frame and scan store engine
// Carries out commands one at a time: pixel read-modify-write, frame fill,
// frame-to-scan copy and quarter emission, plus the clearing pass at reset.
// ============================================================================
module lpq_back import lpq_pkg::*; #(
    parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF,
    parameter int OUT_DEPTH    = OUT_FIFO_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cmd_empty,
    input  t_cmd                           i_cmd,
    output logic                           o_cmd_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0] i_out_level,
    output logic                           o_out_push,
    output t_result                        o_out_data,
    output t_back_status                   o_status
);

    localparam int ROW_BYTES     = (PANEL_WIDTH + 7) / 8;
    localparam int FRAME_BYTES   = ROW_BYTES * PANEL_HEIGHT;
    localparam int AW            = $clog2(FRAME_BYTES);
    localparam int QROWS         = (PANEL_HEIGHT + 3) / 4;
    localparam int QUARTER_BYTES = ROW_BYTES * QROWS;
    localparam int KW            = $clog2(QUARTER_BYTES + 1);
    localparam int XBW           = $clog2(ROW_BYTES + 1);
    localparam int JW            = $clog2(QROWS + 1);
    localparam int ROW_STEP      = 4 * ROW_BYTES;
    localparam logic [AW-1:0] LAST_ADDR = AW'(FRAME_BYTES - 1);

    logic [7:0]     frame_mem [FRAME_BYTES];
    logic [7:0]     scan_mem  [FRAME_BYTES];

    t_back_state    r_state;
    t_back_state    n_state;
    logic [AW-1:0]  r_addr;
    t_cmd           r_cmd;
    logic [1:0]     r_q;
    logic [XBW-1:0] r_xb;
    logic [JW-1:0]  r_j;
    logic [KW-1:0]  r_k;
    logic [AW-1:0]  r_col_base;
    logic           r_rd_vld;
    logic           r_rd_pad;
    logic           r_rd_last;
    logic [1:0]     r_rd_q;
    logic           r_cp_vld;
    logic [AW-1:0]  r_cp_addr;
    logic [7:0]     r_frame_rdata;
    logic [7:0]     r_scan_rdata;

    logic           sweep_last;
    logic           emit_room;
    logic           emit_step;
    logic           emit_last;
    logic           in_cols;
    logic [JW-1:0]  q_rows;
    logic           col_end;
    logic [AW-1:0]  cmd_addr;
    logic [7:0]     pix_mask;
    logic [7:0]     pix_merged;
    logic [AW-1:0]  start_base;

    logic           frame_we;
    logic [AW-1:0]  frame_waddr;
    logic [7:0]     frame_wdata;
    logic [AW-1:0]  frame_raddr;
    logic           scan_we;
    logic [AW-1:0]  scan_waddr;
    logic [7:0]     scan_wdata;

    assign sweep_last = (r_addr == LAST_ADDR);
    // Room for this byte and for the one already being read.
    assign emit_room  = (int'(i_out_level) + int'(r_rd_vld)) <= (OUT_DEPTH - 2);
    assign emit_step  = (r_state == BK_EMIT) && emit_room;
    assign emit_last  = (r_k == KW'(QUARTER_BYTES - 1));
    assign in_cols    = (r_xb < XBW'(ROW_BYTES));
    assign q_rows     = JW'(((PANEL_HEIGHT - 4 + int'(r_q)) >> 2) + 1);
    assign col_end    = (r_j == q_rows - 1'b1);
    assign cmd_addr   = r_cmd.addr[AW-1:0];
    assign pix_mask   = 8'd1 << r_cmd.bit_sel;
    assign pix_merged = r_cmd.data[0] ? (r_frame_rdata | pix_mask)
                                      : (r_frame_rdata & ~pix_mask);
    // Bottom row of the quarter, first column byte.
    assign start_base = AW'((PANEL_HEIGHT - 4 + int'(i_cmd.quarter)) * ROW_BYTES);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_CLEAR: begin
                if (sweep_last) begin
                    n_state = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (!i_cmd_empty) begin
                    unique case (i_cmd.op)
                        CMD_PIXEL:  n_state = BK_PIX_RD;
                        CMD_FILL:   n_state = BK_FILL;
                        CMD_COMMIT: n_state = BK_COPY;
                        CMD_EMIT:   n_state = BK_EMIT;
                        default:    n_state = BK_IDLE;
                    endcase
                end
            end
            BK_FILL, BK_COPY: begin
                if (sweep_last) begin
                    n_state = BK_IDLE;
                end
            end
            BK_PIX_RD: n_state = BK_PIX_WR;
            BK_PIX_WR: n_state = BK_IDLE;
            BK_EMIT: begin
                if (emit_step && emit_last) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_pop   = 1'b0;
        frame_we    = 1'b0;
        frame_waddr = r_addr;
        frame_wdata = '0;
        frame_raddr = r_addr;
        scan_we     = 1'b0;
        scan_waddr  = r_addr;
        scan_wdata  = '0;
        unique case (r_state)
            BK_CLEAR: begin
                frame_we = 1'b1;
                scan_we  = 1'b1;
            end
            BK_IDLE: begin
                o_cmd_pop = !i_cmd_empty;
            end
            BK_FILL: begin
                frame_we    = 1'b1;
                frame_wdata = r_cmd.data;
            end
            BK_PIX_RD: begin
                frame_raddr = cmd_addr;
            end
            BK_PIX_WR: begin
                frame_we    = 1'b1;
                frame_waddr = cmd_addr;
                frame_wdata = pix_merged;
            end
            default: begin
            end
        endcase
        // Each copy write lands in the cycle after its frame read.
        if (r_cp_vld) begin
            scan_we    = 1'b1;
            scan_waddr = r_cp_addr;
            scan_wdata = r_frame_rdata;
        end
    end

    assign o_out_push                = r_rd_vld;
    assign o_out_data.data_byte      = r_rd_pad ? 8'd0 : r_scan_rdata;
    assign o_out_data.row_select     = r_rd_q;
    assign o_out_data.last_of_quarter = r_rd_last;
    assign o_status.clearing         = (r_state == BK_CLEAR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_CLEAR;
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
            r_cp_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= emit_step;
            r_cp_vld <= (r_state == BK_COPY);
            if ((r_state == BK_CLEAR) || (r_state == BK_FILL) || (r_state == BK_COPY)) begin
                r_addr <= sweep_last ? '0 : r_addr + 1'b1;
            end else if (o_cmd_pop) begin
                r_addr <= (i_cmd.op == CMD_EMIT) ? start_base : '0;
            end else if (emit_step && in_cols) begin
                if (col_end) begin
                    r_addr <= r_col_base + AW'(r_xb) + 1'b1;
                end else begin
                    r_addr <= r_addr - AW'(ROW_STEP);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp_addr <= r_addr;
        if (o_cmd_pop) begin
            r_cmd      <= i_cmd;
            r_q        <= i_cmd.quarter;
            r_col_base <= start_base;
            r_xb       <= '0;
            r_j        <= '0;
            r_k        <= '0;
        end else if (emit_step) begin
            r_k <= r_k + 1'b1;
            if (in_cols) begin
                if (col_end) begin
                    r_j  <= '0;
                    r_xb <= r_xb + 1'b1;
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end
        end
        if (emit_step) begin
            r_rd_pad  <= !in_cols;
            r_rd_last <= emit_last;
            r_rd_q    <= r_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (frame_we) begin
            frame_mem[frame_waddr] <= frame_wdata;
        end
        r_frame_rdata <= frame_mem[frame_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (scan_we) begin
            scan_mem[scan_waddr] <= scan_wdata;
        end
        r_scan_rdata <= scan_mem[r_addr];
    end

`ifndef SYNTHESIS
    a_out_never_overflows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (int'(i_out_level) < OUT_DEPTH))
        else $error("result pushed into a full output queue");

    a_copy_write_in_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cp_vld |-> ((r_state == BK_COPY) || (r_state == BK_IDLE)))
        else $error("scan store copy write outside a commit");

    a_emit_ends_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_step && emit_last)
        |=> (r_rd_vld && r_rd_last && (r_state == BK_IDLE)))
        else $error("quarter emission did not end on its last byte");
`endif

endmodule

### sv/led_panel_quarter_scan_driver_unit.sv
// ============================================================================
// led_panel_quarter_scan_driver_unit: monochrome LED panel driver, 1/4 scan
// Frame store with pixel, fill, commit, show, off and tick requests, and a
// stream of quarter bytes for the panel shift register.
// ============================================================================
// Requests enter through a queue-like port (push/full) and the panel bytes
// leave through another (empty/pop), so the block can be dropped between
// two FIFOs. After reset the frame and scan stores are cleared one byte per
// cycle, FRAME_BYTES bytes in all (64 at the default 32x16 panel), and full
// stays high until that pass is done; configuration writes are taken at any
// time but must only be issued while the block is idle. A front end decodes
// each request and hands the real work to a back end through a four-entry
// command queue, so requests keep flowing while the back end is busy. The
// back end owns the two byte-wide stores, each with one read and one write
// port, and its work sets the rate: every command is first taken from the
// queue, then a pixel is read and then merged and written back, fill, off
// and commit sweep the whole frame, and a tick that sends a quarter produces
// QUARTER_BYTES result bytes (16 by default) at one byte per cycle from the
// scan store read port, slowed only if the consumer stops popping. Show,
// ticks that only count and pixels off the screen are handled by the front
// end alone and never reach the back end. Each quarter is sent column byte
// by column byte, rows from the bottom upward in steps of four; the row
// address rides along on row_select and last_of_quarter marks the byte
// after which the panel should latch.
// ============================================================================
module led_panel_quarter_scan_driver_unit import lpq_pkg::*; #(
    parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,

    // Request side.
    input  logic                  push,
    output logic                  full,
    input  logic [2:0]            i_action,
    input  logic signed [15:0]    i_pos_x,
    input  logic signed [15:0]    i_pos_y,
    input  logic                  i_pixel_on,

    // Result side.
    output logic                  empty,
    input  logic                  pop,
    output logic [7:0]            o_data_byte,
    output logic [1:0]            o_row_select,
    output logic                  o_last_of_quarter
);

    localparam int CMD_W = $bits(t_cmd);
    localparam int RES_W = $bits(t_result);

    t_back_status                        back_status;
    logic                                cmd_push;
    t_cmd                                cmd_wdata;
    logic                                cmd_full;
    logic                                cmd_empty;
    logic                                cmd_pop;
    t_cmd                                cmd_rdata;
    logic                                out_push;
    t_result                             out_wdata;
    t_result                             out_rdata;
    logic                                out_full;
    logic [$clog2(OUT_FIFO_DEPTH+1)-1:0] out_level;

    // Front end: decodes requests, keeps the refresh mode.
    lpq_front #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_push        (push),
        .o_full        (full),
        .i_action      (i_action),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pixel_on    (i_pixel_on),
        .i_back_status (back_status),
        .i_cmd_full    (cmd_full),
        .o_cmd_push    (cmd_push),
        .o_cmd         (cmd_wdata)
    );

    // Command queue between the two halves.
    lpq_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_FIFO_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_wdata (cmd_wdata),
        .i_pop   (cmd_pop),
        .o_rdata (cmd_rdata),
        .o_full  (cmd_full),
        .o_empty (cmd_empty),
        .o_level ()
    );

    // Back end: frame and scan stores.
    lpq_back #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT),
        .OUT_DEPTH    (OUT_FIFO_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd_rdata),
        .o_cmd_pop   (cmd_pop),
        .i_out_level (out_level),
        .o_out_push  (out_push),
        .o_out_data  (out_wdata),
        .o_status    (back_status)
    );

    // Result queue; its head is what the consumer sees.
    lpq_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_FIFO_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_wdata (out_wdata),
        .i_pop   (pop),
        .o_rdata (out_rdata),
        .o_full  (out_full),
        .o_empty (empty),
        .o_level (out_level)
    );

    assign o_data_byte       = out_rdata.data_byte;
    assign o_row_select      = out_rdata.row_select;
    assign o_last_of_quarter = out_rdata.last_of_quarter;

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_push |-> !out_full)
        else $error("back end pushed a result into a full queue");
`endif

endmodule
